>>> rtl/scdo_pkg.sv
// constants and helpers for the sphere/capsule deepest-overlap block
// no dependencies; imported by sphere_capsule_deepest_overlap_top and tb_top
package scdo_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
  localparam longint MIN_RADIUS  = (ONE_Q + 50) / 100;
  localparam longint DIR_EPS     = (ONE_Q + 5000) / 10000;
  localparam longint SWITCH_DIST = ONE_Q / 4;
  localparam longint SPAN2       = MIN_RADIUS * MIN_RADIUS;
  localparam longint UNIT16      = 65536;
  localparam longint DIFF_LIM    = longint'(1) << 30;

  localparam int KEY_W  = 40;
  localparam int NRM_W  = 18;
  localparam int PEN_W  = 33;
  localparam int RAD_W  = 31;
  localparam int INT_W  = 17;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_PREV  = 2'd1;
  localparam logic [1:0] CMD_SHAPE = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // clamp a difference to +-2^30
  function automatic coord_t sat_diff(input logic signed [COORD_WIDTH:0] v);
    logic signed [COORD_WIDTH:0] lim;
    lim = (COORD_WIDTH+1)'(DIFF_LIM);
    if (v > lim) begin
      sat_diff = COORD_WIDTH'(DIFF_LIM);
    end else if (v < -lim) begin
      sat_diff = COORD_WIDTH'(-DIFF_LIM);
    end else begin
      sat_diff = v[COORD_WIDTH-1:0];
    end
  endfunction

endpackage

>>> rtl/sphere_capsule_deepest_overlap_top.sv
// sphere against capsule deepest-overlap unit, one shared multiplier,
// divider step and square-root step under a small sequencer; uses scdo_pkg
//
// Items arrive on the s_axis port: a begin beat opens a query (centre, radius
// raised to at least 0.01, blend fraction), a load beat stores a previous
// capsule, and a shape beat is blended toward any stored capsule and tested
// against the query sphere. Begin, load and unknown beats go straight back to
// idle unless they carry tlast. A shape beat keeps s_axis_tready low after it
// is taken while the sequencer runs the blend multiplies when a previous
// capsule is stored, the differences, the dot products, the segment fraction
// divide when needed, the offset and its squares, the square root, the overlap
// check and, on an overlap, the normal divides and the update; each
// zero-distance fallback repeats the squares, the root and the check. The
// multiplier is shared, and the divider and the root produce one bit per
// cycle. A beat with tlast then has the result loaded in ST_FIN; it is then
// held on m_axis until taken, with s_axis_tready low meanwhile.
module sphere_capsule_deepest_overlap_top
  import scdo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, radius, interp, shape_key, from bit 0
  input  logic [279:0] s_axis_tdata,
  // cmd, preferred, from bit 0
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_key, normal_x, normal_y, normal_z, penetration, from bit 0
  output logic [127:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BLEND  = 4'd1;
  localparam logic [3:0] ST_DIFF   = 4'd2;
  localparam logic [3:0] ST_DOT    = 4'd3;
  localparam logic [3:0] ST_TSEL   = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_NCOMP  = 4'd6;
  localparam logic [3:0] ST_SUMSQ  = 4'd7;
  localparam logic [3:0] ST_SQRT   = 4'd8;
  localparam logic [3:0] ST_CHECK  = 4'd9;
  localparam logic [3:0] ST_UNIT   = 4'd10;
  localparam logic [3:0] ST_UDONE  = 4'd11;
  localparam logic [3:0] ST_UPDATE = 4'd12;
  localparam logic [3:0] ST_FIN    = 4'd13;
  localparam logic [3:0] ST_OUT    = 4'd14;

  localparam int CW = COORD_WIDTH;

  logic [3:0] state_q;
  logic [2:0] cnt_q;
  logic [4:0] scnt_q;
  logic [1:0] fb_q;
  logic       div_t_q;

  coord_t            a_q [3];
  coord_t            b_q [3];
  logic [RAD_W-1:0]  rad_q;
  logic [KEY_W-1:0]  key_q;
  logic              pref_q;
  logic              last_q;

  coord_t            qc_q [3];
  logic [RAD_W-1:0]  qrad_q;
  logic [INT_W-1:0]  qint_q;

  coord_t            pp_q [6];
  logic [RAD_W-1:0]  prad_q;
  logic              prev_valid_q;

  coord_t            s_q [3];
  coord_t            w_q [3];
  logic signed [CW:0] v_q [3];
  logic [63:0]       acc_q;
  logic signed [63:0] dot_q;
  logic [INT_W-1:0]  t_q;

  logic [63:0]       drem_q;
  logic [63:0]       dden_q;
  logic [15:0]       dquo_q;
  logic [63:0]       sx_q;
  logic [63:0]       sr_q;
  logic [63:0]       sbit_q;

  logic [31:0]       len_q;
  logic [31:0]       dist_q;
  logic [PEN_W-1:0]  comb_q;
  logic signed [NRM_W-1:0] nrm_q [3];

  logic              bv_q;
  logic [KEY_W-1:0]  bkey_q;
  logic signed [NRM_W-1:0] bnrm_q [3];
  logic [PEN_W-1:0]  bpen_q;
  logic              pv_q;
  logic [KEY_W-1:0]  pkey_q;
  logic signed [NRM_W-1:0] pnrm_q [3];
  logic [PEN_W-1:0]  ppen_q;

  logic              out_valid_q;
  logic              out_hit_q;
  logic [KEY_W-1:0]  out_key_q;
  logic signed [NRM_W-1:0] out_n_q [3];
  logic [31:0]       out_pen_q;

  // input unpacking
  coord_t           in_a [3];
  coord_t           in_b [3];
  logic [RAD_W-1:0] in_rad;
  logic [INT_W-1:0] in_int;
  logic [KEY_W-1:0] in_key;
  logic [1:0]       in_cmd;
  logic             in_accept;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata[32*i +: 32];
      in_b[i] = s_axis_tdata[96 + 32*i +: 32];
    end
  end
  assign in_rad    = s_axis_tdata[222:192];
  assign in_int    = s_axis_tdata[239:223];
  assign in_key    = s_axis_tdata[279:240];
  assign in_cmd    = s_axis_tuser[1:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {2'b00, out_pen_q, out_n_q[2], out_n_q[1], out_n_q[0], out_key_q};

  // shared multiplier and operand selection
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;
  logic signed [67:0] rnd;
  logic signed [33:0] bl_cur;
  logic signed [33:0] bl_prev;
  logic [1:0]         ei;

  assign ei = cnt_q[1:0];

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    bl_cur  = '0;
    bl_prev = '0;
    case (state_q)
      ST_BLEND: begin
        case (cnt_q)
          3'd0, 3'd1, 3'd2: begin
            bl_cur  = 34'(a_q[ei]);
            bl_prev = 34'(pp_q[ei]);
          end
          3'd3: begin bl_cur = 34'(b_q[0]); bl_prev = 34'(pp_q[3]); end
          3'd4: begin bl_cur = 34'(b_q[1]); bl_prev = 34'(pp_q[4]); end
          3'd5: begin bl_cur = 34'(b_q[2]); bl_prev = 34'(pp_q[5]); end
          default: begin
            bl_cur  = $signed({3'b000, rad_q});
            bl_prev = $signed({3'b000, prad_q});
          end
        endcase
        mul_a = bl_cur - bl_prev;
        mul_b = $signed({17'd0, qint_q});
      end
      ST_DOT: begin
        if (cnt_q < 3'd3) begin
          mul_a = 34'(s_q[ei]);
          mul_b = 34'(s_q[ei]);
        end else begin
          mul_a = 34'(w_q[2'(cnt_q - 3'd3)]);
          mul_b = 34'(s_q[2'(cnt_q - 3'd3)]);
        end
      end
      ST_NCOMP: begin
        mul_a = 34'(s_q[ei]);
        mul_b = $signed({17'd0, t_q});
      end
      ST_SUMSQ: begin
        mul_a = 34'(v_q[ei]);
        mul_b = 34'(v_q[ei]);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign rnd  = (prod + 68'sd32768) >>> 16;

  // divider step, one quotient bit per cycle
  logic [63:0] div_r2;
  logic        div_ge;
  logic [15:0] div_q_n;
  assign div_r2  = {drem_q[62:0], 1'b0};
  assign div_ge  = (div_r2 >= dden_q);
  assign div_q_n = {dquo_q[14:0], div_ge};

  // square-root step, one result bit per cycle
  logic [63:0] sq_rb;
  logic        sq_ge;
  assign sq_rb = sr_q + sbit_q;
  assign sq_ge = (sx_q >= sq_rb);

  logic [31:0]      root;
  logic [PEN_W-1:0] comb_n;
  logic [PEN_W-1:0] pen_n;
  logic [32:0]      umag;
  logic [PEN_W-1:0] gap;
  logic             use_pref;
  assign root     = sr_q[31:0];
  assign comb_n   = {2'b00, qrad_q} + {2'b00, rad_q};
  assign pen_n    = comb_q - {1'b0, dist_q};
  assign umag     = v_q[ei][CW] ? 33'(-v_q[ei]) : 33'(v_q[ei]);
  assign gap      = bpen_q - ppen_q;
  assign use_pref = pv_q && (gap <= PEN_W'(SWITCH_DIST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      scnt_q       <= '0;
      fb_q         <= '0;
      div_t_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        qc_q[i]   <= '0;
        bnrm_q[i] <= '0;
        pnrm_q[i] <= '0;
      end
      qrad_q       <= '0;
      qint_q       <= '0;
      prev_valid_q <= 1'b0;
      bv_q         <= 1'b0;
      bkey_q       <= '0;
      bpen_q       <= '0;
      pv_q         <= 1'b0;
      pkey_q       <= '0;
      ppen_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            last_q <= s_axis_tlast;
            a_q    <= in_a;
            b_q    <= in_b;
            rad_q  <= in_rad;
            key_q  <= in_key;
            pref_q <= s_axis_tuser[2];
            cnt_q  <= '0;
            state_q <= s_axis_tlast ? ST_FIN : ST_IDLE;
            case (in_cmd)
              CMD_BEGIN: begin
                qc_q   <= in_a;
                qrad_q <= (in_rad < RAD_W'(MIN_RADIUS)) ? RAD_W'(MIN_RADIUS) : in_rad;
                qint_q <= (in_int > INT_W'(UNIT16)) ? INT_W'(UNIT16) : in_int;
                prev_valid_q <= 1'b0;
                bv_q <= 1'b0;
                pv_q <= 1'b0;
              end
              CMD_PREV: begin
                for (int i = 0; i < 3; i++) begin
                  pp_q[i]     <= in_a[i];
                  pp_q[3 + i] <= in_b[i];
                end
                prad_q       <= in_rad;
                prev_valid_q <= 1'b1;
              end
              CMD_SHAPE: begin
                state_q <= prev_valid_q ? ST_BLEND : ST_DIFF;
              end
              default: ;
            endcase
          end
        end
        ST_BLEND: begin
          case (cnt_q)
            3'd0, 3'd1, 3'd2: a_q[ei] <= CW'(bl_prev + rnd[33:0]);
            3'd3: b_q[0] <= CW'(bl_prev + rnd[33:0]);
            3'd4: b_q[1] <= CW'(bl_prev + rnd[33:0]);
            3'd5: b_q[2] <= CW'(bl_prev + rnd[33:0]);
            default: rad_q <= RAD_W'(bl_prev + rnd[33:0]);
          endcase
          if (cnt_q == 3'd6) begin
            prev_valid_q <= 1'b0;
            state_q      <= ST_DIFF;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            s_q[i] <= sat_diff((CW+1)'(b_q[i]) - (CW+1)'(a_q[i]));
            w_q[i] <= sat_diff((CW+1)'(qc_q[i]) - (CW+1)'(a_q[i]));
          end
          acc_q   <= '0;
          dot_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DOT;
        end
        ST_DOT: begin
          if (cnt_q < 3'd3) begin
            acc_q <= acc_q + prod[63:0];
          end else begin
            dot_q <= dot_q + prod[63:0];
          end
          if (cnt_q == 3'd5) begin
            state_q <= ST_TSEL;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_TSEL: begin
          cnt_q <= '0;
          if (acc_q > 64'(SPAN2) && dot_q > 64'sd0) begin
            if ($unsigned(dot_q) >= acc_q) begin
              t_q     <= INT_W'(UNIT16);
              state_q <= ST_NCOMP;
            end else begin
              drem_q  <= $unsigned(dot_q);
              dden_q  <= acc_q;
              dquo_q  <= '0;
              scnt_q  <= '0;
              div_t_q <= 1'b1;
              state_q <= ST_DIV;
            end
          end else begin
            t_q     <= '0;
            state_q <= ST_NCOMP;
          end
        end
        ST_DIV: begin
          drem_q <= div_ge ? (div_r2 - dden_q) : div_r2;
          dquo_q <= div_q_n;
          scnt_q <= scnt_q + 5'd1;
          if (scnt_q == 5'd15) begin
            if (div_t_q) begin
              t_q     <= {1'b0, div_q_n};
              state_q <= ST_NCOMP;
            end else begin
              state_q <= ST_UDONE;
            end
          end
        end
        ST_NCOMP: begin
          v_q[ei] <= (CW+1)'(w_q[ei]) - rnd[CW:0];
          if (cnt_q == 3'd2) begin
            cnt_q   <= '0;
            acc_q   <= '0;
            fb_q    <= '0;
            state_q <= ST_SUMSQ;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_SUMSQ: begin
          acc_q <= acc_q + prod[63:0];
          if (cnt_q == 3'd2) begin
            sx_q    <= acc_q + prod[63:0];
            sr_q    <= '0;
            sbit_q  <= 64'd1 << 62;
            scnt_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sx_q <= sx_q - sq_rb;
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          scnt_q <= scnt_q + 5'd1;
          if (scnt_q == 5'd31) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt_q <= '0;
          if (fb_q == 2'd0 && {1'b0, root} >= comb_n) begin
            // no overlap with this shape
            state_q <= last_q ? ST_FIN : ST_IDLE;
          end else begin
            if (fb_q == 2'd0) begin
              dist_q <= root;
              comb_q <= comb_n;
            end
            if (root > 32'(DIR_EPS)) begin
              len_q   <= root;
              state_q <= ST_UNIT;
            end else if (fb_q != 2'd2) begin
              // zero distance: fall back to a direction across the segment
              if (fb_q == 2'd0) begin
                v_q[0] <= (CW+1)'(s_q[1]);
                v_q[1] <= -(CW+1)'(s_q[0]);
                v_q[2] <= '0;
              end else begin
                v_q[0] <= '0;
                v_q[1] <= (CW+1)'(s_q[2]);
                v_q[2] <= -(CW+1)'(s_q[1]);
              end
              fb_q    <= fb_q + 2'd1;
              acc_q   <= '0;
              state_q <= ST_SUMSQ;
            end else begin
              nrm_q[0] <= '0;
              nrm_q[1] <= NRM_W'(UNIT16);
              nrm_q[2] <= '0;
              state_q  <= ST_UPDATE;
            end
          end
        end
        ST_UNIT: begin
          if (umag >= {1'b0, len_q}) begin
            nrm_q[ei] <= v_q[ei][CW] ? -NRM_W'(UNIT16) : NRM_W'(UNIT16);
            if (cnt_q == 3'd2) begin
              state_q <= ST_UPDATE;
            end else begin
              cnt_q <= cnt_q + 3'd1;
            end
          end else begin
            drem_q  <= 64'(umag);
            dden_q  <= 64'(len_q);
            dquo_q  <= '0;
            scnt_q  <= '0;
            div_t_q <= 1'b0;
            state_q <= ST_DIV;
          end
        end
        ST_UDONE: begin
          nrm_q[ei] <= v_q[ei][CW] ? -NRM_W'(dquo_q) : NRM_W'(dquo_q);
          if (cnt_q == 3'd2) begin
            state_q <= ST_UPDATE;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= ST_UNIT;
          end
        end
        ST_UPDATE: begin
          if (!bv_q || pen_n > bpen_q) begin
            bv_q   <= 1'b1;
            bkey_q <= key_q;
            bnrm_q <= nrm_q;
            bpen_q <= pen_n;
          end
          if (pref_q && (!pv_q || pen_n > ppen_q)) begin
            pv_q   <= 1'b1;
            pkey_q <= key_q;
            pnrm_q <= nrm_q;
            ppen_q <= pen_n;
          end
          state_q <= last_q ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          out_valid_q <= 1'b1;
          out_hit_q   <= bv_q;
          if (!bv_q) begin
            out_key_q <= '0;
            out_pen_q <= '0;
            for (int i = 0; i < 3; i++) out_n_q[i] <= '0;
          end else if (use_pref) begin
            out_key_q <= pkey_q;
            out_pen_q <= ppen_q[31:0];
            out_n_q   <= pnrm_q;
          end else begin
            out_key_q <= bkey_q;
            out_pen_q <= bpen_q[31:0];
            out_n_q   <= bnrm_q;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> dv/tb_top.sv
// self-checking bench for sphere_capsule_deepest_overlap_top: a queue-fed beat
// driver, a result monitor and an in-bench overlap predictor; uses scdo_pkg
`timescale 1ns / 1ps

module tb_top;
  import scdo_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam longint BLEND_SAT = longint'(1) << 45;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic [30:0]        rad;
    logic [16:0]        interp;
    logic [39:0]        key;
    bit                 pref, last, hold;
  } shape_beat_t;

  typedef struct {
    bit          hit;
    logic [39:0] key;
    logic [17:0] nx, ny, nz;
    logic [31:0] pen;
  } overlap_t;

  typedef struct {
    logic [39:0]     key;
    longint          n0, n1, n2;
    longint unsigned pen;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [279:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic m_axis_tuser;

  sphere_capsule_deepest_overlap_top dut (.*);

  always #10 clk_i = ~clk_i;

  shape_beat_t beat_queue[$];
  overlap_t    expected_hits[$];
  shape_beat_t cur_beat;
  int          beats_sent = 0;
  int          err_count = 0;
  int          send_idle, recv_idle;

  // predictor state
  longint          q_ctr[3];
  longint unsigned q_rad, q_frac;
  longint          prv_pt[6];
  longint          prv_rad;
  bit              prv_ok, deep_ok, pick_ok;
  contact_t        deep, pick;
  longint          cap_a[3], cap_b[3];

  function automatic void queue_beat(shape_beat_t b);
    beat_queue.insert(beat_queue.size(), b);
  endfunction

  function automatic longint clampv(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned frac_q16(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned len3(longint c0, longint c1, longint c2);
    return isqrt(longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2));
  endfunction

  function automatic longint unit_q16(longint c, longint unsigned len);
    longint unsigned mag, q;
    mag = c < 0 ? -c : c;
    q = (mag << 16) / len;
    if (q > UNIT16) q = UNIT16;
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint blend_q16(longint p, longint c);
    return p + ((clampv(c - p, BLEND_SAT) * longint'(q_frac) + 32768) >>> 16);
  endfunction

  task automatic test_capsule(longint unsigned rad, logic [39:0] key, bit pref);
    longint s[3], w[3], n[3];
    longint dot, t;
    longint unsigned lsq, off_len, comb, l;
    contact_t c;
    lsq = 0;
    dot = 0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = clampv(cap_b[i] - cap_a[i], DIFF_LIM);
      w[i] = clampv(q_ctr[i] - cap_a[i], DIFF_LIM);
      lsq += s[i] * s[i];
      dot += w[i] * s[i];
    end
    if (lsq > SPAN2 && dot > 0)
      t = (longint'(unsigned'(dot)) >= 0 && dot >= lsq) ? UNIT16 : frac_q16(dot, lsq);
    for (int i = 0; i < 3; i++) n[i] = w[i] - ((s[i] * t + 32768) >>> 16);
    off_len = len3(n[0], n[1], n[2]);
    comb = q_rad + rad;
    if (off_len >= comb) return;
    if (off_len > DIR_EPS) begin
      c.n0 = unit_q16(n[0], off_len);
      c.n1 = unit_q16(n[1], off_len);
      c.n2 = unit_q16(n[2], off_len);
    end else begin
      // degenerate offset: fall back to a direction across the segment
      l = len3(s[1], -s[0], 0);
      if (l > DIR_EPS) begin
        c.n0 = unit_q16(s[1], l); c.n1 = unit_q16(-s[0], l); c.n2 = 0;
      end else begin
        l = len3(0, s[2], -s[1]);
        if (l > DIR_EPS) begin
          c.n0 = 0; c.n1 = unit_q16(s[2], l); c.n2 = unit_q16(-s[1], l);
        end else begin
          c.n0 = 0; c.n1 = UNIT16; c.n2 = 0;
        end
      end
    end
    c.key = key;
    c.pen = comb - off_len;
    if (!deep_ok || c.pen > deep.pen) begin
      deep = c;
      deep_ok = 1;
    end
    if (pref && (!pick_ok || c.pen > pick.pen)) begin
      pick = c;
      pick_ok = 1;
    end
  endtask

  task automatic predict_beat(shape_beat_t bt);
    longint unsigned rad;
    overlap_t o;
    contact_t r;
    rad = bt.rad;
    cap_a[0] = bt.ax; cap_a[1] = bt.ay; cap_a[2] = bt.az;
    cap_b[0] = bt.bx; cap_b[1] = bt.by; cap_b[2] = bt.bz;
    case (bt.cmd)
      CMD_BEGIN: begin
        for (int i = 0; i < 3; i++) q_ctr[i] = cap_a[i];
        q_rad = rad < MIN_RADIUS ? MIN_RADIUS : rad;
        q_frac = bt.interp > UNIT16 ? UNIT16 : bt.interp;
        prv_ok = 0;
        deep_ok = 0;
        pick_ok = 0;
      end
      CMD_PREV: begin
        for (int i = 0; i < 3; i++) begin
          prv_pt[i] = cap_a[i];
          prv_pt[3+i] = cap_b[i];
        end
        prv_rad = rad;
        prv_ok = 1;
      end
      CMD_SHAPE: begin
        if (prv_ok) begin
          for (int i = 0; i < 3; i++) begin
            cap_a[i] = blend_q16(prv_pt[i], cap_a[i]);
            cap_b[i] = blend_q16(prv_pt[3+i], cap_b[i]);
          end
          rad = blend_q16(prv_rad, rad);
          prv_ok = 0;
        end
        test_capsule(rad, bt.key, bt.pref);
      end
      default: ;
    endcase
    if (!bt.last) return;
    o = '{default: '0};
    if (deep_ok) begin
      r = deep;
      if (pick_ok && deep.pen - pick.pen <= SWITCH_DIST) r = pick;
      o.hit = 1;
      o.key = r.key;
      o.nx = r.n0[17:0];
      o.ny = r.n1[17:0];
      o.nz = r.n2[17:0];
      o.pen = r.pen[31:0];
    end
    expected_hits.insert(expected_hits.size(), o);
  endtask

  // idling per phase: sender 6 / receiver 70, then swapped, then none
  always_comb begin
    if (beats_sent < 650) begin
      send_idle = 6; recv_idle = 70;
    end else if (beats_sent < 1300) begin
      send_idle = 70; recv_idle = 6;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  end

  // driver
  always @(posedge clk_i) begin
    bit took, busy, hold_off;
    took = s_axis_tvalid && s_axis_tready;
    busy = s_axis_tvalid && !s_axis_tready;
    if (took) begin
      predict_beat(cur_beat);
      beats_sent++;
    end
    if (rst_ni && !busy) begin
      hold_off = beat_queue.size() > 0 && beat_queue[0].hold && expected_hits.size() > 0;
      if (beat_queue.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
        cur_beat = beat_queue.pop_front();
        s_axis_tdata <= {cur_beat.key, cur_beat.interp, cur_beat.rad, cur_beat.bz,
                         cur_beat.by, cur_beat.bx, cur_beat.az, cur_beat.ay, cur_beat.ax};
        s_axis_tuser <= {cur_beat.pref, cur_beat.cmd};
        s_axis_tlast <= cur_beat.last;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    overlap_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_hits.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        e = expected_hits.pop_front();
        if (m_axis_tuser !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, m_axis_tuser); err_count++;
        end
        if (m_axis_tdata[39:0] !== e.key) begin
          $error("hit_key: expected %h, got %h", e.key, m_axis_tdata[39:0]); err_count++;
        end
        if (m_axis_tdata[57:40] !== e.nx) begin
          $error("normal_x: expected %h, got %h", e.nx, m_axis_tdata[57:40]); err_count++;
        end
        if (m_axis_tdata[75:58] !== e.ny) begin
          $error("normal_y: expected %h, got %h", e.ny, m_axis_tdata[75:58]); err_count++;
        end
        if (m_axis_tdata[93:76] !== e.nz) begin
          $error("normal_z: expected %h, got %h", e.nz, m_axis_tdata[93:76]); err_count++;
        end
        if (m_axis_tdata[125:94] !== e.pen) begin
          $error("penetration: expected %h, got %h", e.pen, m_axis_tdata[125:94]); err_count++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any beat
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic shape_beat_t mk(logic [1:0] cmd, longint ax, longint ay, longint az,
                                     longint bx, longint by, longint bz, longint rad,
                                     longint interp, bit pref, bit last);
    shape_beat_t b;
    b.cmd = cmd;
    b.ax = 32'(ax); b.ay = 32'(ay); b.az = 32'(az);
    b.bx = 32'(bx); b.by = 32'(by); b.bz = 32'(bz);
    b.rad = 31'(rad);
    b.interp = 17'(interp);
    b.key = 40'({$urandom, $urandom});
    b.pref = pref;
    b.last = last;
    b.hold = 0;
    return b;
  endfunction

  function automatic longint near(longint c, int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic longint full32();
    return longint'(signed'($urandom));
  endfunction

  task automatic add_query();
    longint cx, cy, cz, ex, ey, ez;
    int nshape, sp;
    shape_beat_t b;
    bit wild;
    wild = $urandom_range(9) == 0;
    cx = wild ? full32() : near(0, 1 << 24);
    cy = wild ? full32() : near(0, 1 << 24);
    cz = wild ? full32() : near(0, 1 << 24);
    b = mk(CMD_BEGIN, cx, cy, cz, full32(), full32(), full32(),
           $urandom_range(3) == 0 ? $urandom_range(700) : $urandom_range(1 << 17),
           $urandom_range(3) == 0 ? $urandom_range(131071) : $urandom_range(65536), 0, 0);
    b.key = 40'({$urandom, $urandom});
    nshape = $urandom_range(5);
    if (nshape == 0) b.last = 1;
    b.hold = $urandom_range(60) == 0;
    queue_beat(b);
    for (int k = 0; k < nshape; k++) begin
      sp = $urandom_range(1) ? (3 << 16) : (1 << 12);
      if ($urandom_range(2) == 0)
        queue_beat(mk(CMD_PREV, near(cx, sp), near(cy, sp), near(cz, sp),
                      near(cx, sp), near(cy, sp), near(cz, sp),
                      $urandom_range(1 << 17), 0, $urandom_range(1), 0));
      ex = near(cx, sp); ey = near(cy, sp); ez = near(cz, sp);
      case ($urandom_range(7))
        0: b = mk(CMD_SHAPE, ex, ey, ez, ex, ey, ez, $urandom_range(1 << 17), 0,
                  $urandom_range(1), 0);
        1: b = mk(CMD_SHAPE, cx, cy, near(cz, sp), cx, cy, near(cz, sp),
                  $urandom_range(1 << 17), 0, $urandom_range(1), 0);
        2: b = mk(CMD_SHAPE, full32(), full32(), full32(), full32(), full32(), full32(),
                  $urandom_range(32'h7fffffff), 0, $urandom_range(1), 0);
        default: b = mk(CMD_SHAPE, ex, ey, ez, near(cx, sp), near(cy, sp), near(cz, sp),
                        $urandom_range(1 << 17), 0, $urandom_range(1), 0);
      endcase
      b.last = (k == nshape - 1);
      queue_beat(b);
    end
    if ($urandom_range(30) == 0)
      queue_beat(mk(CMD_UNUSED, full32(), full32(), full32(), full32(), full32(),
                    full32(), $urandom_range(32'h7fffffff), $urandom_range(131071),
                    $urandom_range(1), $urandom_range(1)));
  endtask

  initial begin
    shape_beat_t b;
    longint big, neg;
    big = 32'sh7fffffff;
    neg = -longint'(1) << 31;
    // unknown command with last straight after reset: empty result
    b = mk(CMD_UNUSED, big, big, big, big, big, big, big, 131071, 1, 1);
    b.key = '1;
    queue_beat(b);
    // tiny query radius, over-range fraction, degenerate normals
    queue_beat(mk(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0, 131071, 0, 0));
    queue_beat(mk(CMD_SHAPE, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    queue_beat(mk(CMD_SHAPE, 0, 0, -65536, 0, 0, 65536, 65536, 0, 0, 0));
    queue_beat(mk(CMD_SHAPE, -65536, 0, 0, 65536, 0, 0, 65536, 0, 1, 0));
    b = mk(CMD_SHAPE, big, big, big, neg, neg, neg, big, 0, 1, 1);
    b.key = '1;
    queue_beat(b);
    // last on begin and on load, extremes of the coordinates
    b = mk(CMD_BEGIN, neg, neg, neg, big, big, big, big, 65536, 0, 1);
    b.hold = 1;
    queue_beat(b);
    queue_beat(mk(CMD_PREV, big, neg, big, neg, big, neg, big, 0, 0, 1));
    queue_beat(mk(CMD_SHAPE, neg, big, neg, big, neg, big, 0, 0, 1, 1));
    // half blend, preferred tie, preferred within switch distance
    queue_beat(mk(CMD_BEGIN, 1000, 2000, 3000, 0, 0, 0, 65536, 32768, 0, 0));
    queue_beat(mk(CMD_PREV, 0, 0, 0, 65536, 0, 0, 65536, 0, 0, 0));
    queue_beat(mk(CMD_SHAPE, 0, 65536, 0, 65536, 65536, 0, 32768, 0, 0, 0));
    queue_beat(mk(CMD_SHAPE, 0, 20000, 0, 0, 20000, 0, 65536, 0, 0, 0));
    queue_beat(mk(CMD_SHAPE, 0, 20000, 0, 0, 20000, 0, 65536, 0, 1, 0));
    queue_beat(mk(CMD_SHAPE, 40000, 0, 0, 40000, 0, 0, 65536, 0, 1, 1));
    while (beat_queue.size() < 1950) add_query();
    b = mk(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    queue_beat(b);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (beat_queue.size() > 0 || s_axis_tvalid || expected_hits.size() > 0);
    repeat (300) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sphere_capsule_deepest_overlap_top.f
rtl/scdo_pkg.sv
rtl/sphere_capsule_deepest_overlap_top.sv
dv/tb_top.sv
